FILE: rtl/vtsd_pkg.sv
// Shared types, constants and tables of the vector terminal stream decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package vtsd_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int INTENSITY_ENTRIES = 94;
  localparam int CFG_W             = 13;
  localparam int IDX_W             = 3;
  localparam int DVS_W             = 10;
  localparam int RECIP_SHIFT       = 21;

  localparam logic [12:0] RESET_WIDTH    = 13'd1024;
  localparam logic [12:0] RESET_HEIGHT   = 13'd780;
  // Top line for size 0 at the reset height: 780 - 780 / 35.
  localparam logic [12:0] RESET_CURSOR_Y = 13'd758;

  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TAB_SINGLE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_FULL_RES      = 3'd3;
  localparam logic [IDX_W-1:0] REG_RAW_NEWLINE   = 3'd4;

  localparam logic [6:0] CH_NUL   = 7'd0;
  localparam logic [6:0] CH_ACK   = 7'd6;
  localparam logic [6:0] CH_BEL   = 7'd7;
  localparam logic [6:0] CH_BS    = 7'd8;
  localparam logic [6:0] CH_HT    = 7'd9;
  localparam logic [6:0] CH_LF    = 7'd10;
  localparam logic [6:0] CH_VT    = 7'd11;
  localparam logic [6:0] CH_FF    = 7'd12;
  localparam logic [6:0] CH_CR    = 7'd13;
  localparam logic [6:0] CH_SO    = 7'd14;
  localparam logic [6:0] CH_SI    = 7'd15;
  localparam logic [6:0] CH_ETB   = 7'd23;
  localparam logic [6:0] CH_ESC   = 7'd27;
  localparam logic [6:0] CH_FS    = 7'd28;
  localparam logic [6:0] CH_GS    = 7'd29;
  localparam logic [6:0] CH_RS    = 7'd30;
  localparam logic [6:0] CH_US    = 7'd31;
  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_EIGHT = 7'd56;
  localparam logic [6:0] CH_SEMI  = 7'd59;
  localparam logic [6:0] CH_PEN   = 7'd80;
  localparam logic [6:0] CH_LBRK  = 7'd91;
  localparam logic [6:0] CH_GRAVE = 7'd96;
  localparam logic [6:0] CH_LO_G  = 7'd103;
  localparam logic [6:0] CH_LO_H  = 7'd104;
  localparam logic [6:0] CH_LO_O  = 7'd111;
  localparam logic [6:0] CH_LO_P  = 7'd112;
  localparam logic [6:0] CH_LO_W  = 7'd119;
  localparam logic [6:0] CH_DEL   = 7'd127;

  localparam logic [1:0] TAG_CTL  = 2'd0;
  localparam logic [1:0] TAG_HIGH = 2'd1;
  localparam logic [1:0] TAG_LOWY = 2'd3;

  typedef enum logic [3:0] {
    MODE_ALPHA   = 4'd0,
    MODE_HY      = 4'd1,
    MODE_LY      = 4'd2,
    MODE_HX      = 4'd3,
    MODE_LX      = 4'd4,
    PLOT_HY      = 4'd5,
    PLOT_LY      = 4'd6,
    PLOT_HX      = 4'd7,
    PLOT_LX      = 4'd8,
    MODE_ESC     = 4'd9,
    MODE_INCR    = 4'd10,
    MODE_SPECIAL = 4'd11,
    MODE_SKIP    = 4'd12
  } mode_t;

  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_MOVE      = 4'd1,
    CMD_VECTOR    = 4'd2,
    CMD_POINT     = 4'd3,
    CMD_CHAR      = 4'd4,
    CMD_BELL      = 4'd5,
    CMD_CLEAR     = 4'd6,
    CMD_SIZE      = 4'd7,
    CMD_STYLE     = 4'd8,
    CMD_DUMP      = 4'd9,
    CMD_INTENSITY = 4'd10
  } cmd_t;

  typedef enum logic [3:0] {
    CLS_US, CLS_CR, CLS_ESC, CLS_FF, CLS_BELL, CLS_LF, CLS_FS, CLS_GS, CLS_RS, CLS_DATA
  } cls_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_CELL, BS_PREP, BS_MOD, BS_EXEC
  } bstate_t;

  typedef struct packed {
    cls_t       cls;
    logic [6:0] ch;
  } entry_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic        tab_single;
    logic        full_res;
    logic        raw_nl;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [11:0] from_x;
    logic [11:0] from_y;
    logic [11:0] to_x;
    logic [11:0] to_y;
    logic [6:0]  glyph_code;
    logic [1:0]  glyph_size;
    logic [2:0]  line_style;
    logic        write_through;
    logic [6:0]  beam_intensity;
    logic        defocused;
    logic        alpha_mode;
  } res_t;

  localparam logic [6:0] INTENSITY_TAB [INTENSITY_ENTRIES] = '{
    7'd14, 7'd16, 7'd17, 7'd19, 7'd20, 7'd22, 7'd23, 7'd25,
    7'd28, 7'd31, 7'd34, 7'd38, 7'd41, 7'd44, 7'd47, 7'd50,
    7'd56, 7'd62, 7'd69, 7'd75, 7'd81, 7'd88, 7'd94, 7'd100,
    7'd56, 7'd62, 7'd69, 7'd75, 7'd81, 7'd88, 7'd96, 7'd100,
    7'd0,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd2,
    7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,  7'd3,
    7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,  7'd6,  7'd6,
    7'd7,  7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd12, 7'd13,
    7'd14, 7'd16, 7'd17, 7'd19, 7'd20, 7'd22, 7'd23, 7'd25,
    7'd28, 7'd31, 7'd34, 7'd38, 7'd41, 7'd44, 7'd47, 7'd50,
    7'd56, 7'd62, 7'd69, 7'd75, 7'd81, 7'd88, 7'd94, 7'd100,
    7'd56, 7'd63, 7'd69, 7'd75, 7'd81, 7'd88
  };

  // Cell width in dots: width / {74, 81, 121, 133} by a rounded-up reciprocal of
  // 2^21, exact for every 13-bit width.
  function automatic logic [7:0] cell_width(input logic [12:0] w, input logic [1:0] size);
    logic [15:0] k;
    logic [28:0] p;
    case (size)
      2'd0:    k = 16'd28340;
      2'd1:    k = 16'd25891;
      2'd2:    k = 16'd17332;
      default: k = 16'd15769;
    endcase
    p = {16'b0, w} * {13'b0, k};
    return p[RECIP_SHIFT +: 8];
  endfunction

  // Cell height in dots: height / {35, 38, 58, 64}, same scheme.
  function automatic logic [7:0] cell_height(input logic [12:0] h, input logic [1:0] size);
    logic [15:0] k;
    logic [28:0] p;
    case (size)
      2'd0:    k = 16'd59919;
      2'd1:    k = 16'd55189;
      2'd2:    k = 16'd36158;
      default: k = 16'd32768;
    endcase
    p = {16'b0, h} * {13'b0, k};
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vtsd_front.sv
// Front part: takes received bytes and sorts them into control classes.
// Depends on vtsd_pkg; feeds the request queue.
`timescale 1ns / 1ps
`default_nettype none
module vtsd_front import vtsd_pkg::*; (
  input  wire logic       rx_valid,
  input  wire logic [7:0] rx_byte,
  output logic            rx_ready,
  input  wire logic       q_full,
  output logic            push,
  output entry_t          entry
);

  logic [6:0] ch;

  assign ch       = rx_byte[6:0];
  assign rx_ready = !q_full;
  assign push     = rx_valid && !q_full;

  always_comb begin
    entry.ch = ch;
    unique case (ch)
      CH_US:   entry.cls = CLS_US;
      CH_CR:   entry.cls = CLS_CR;
      CH_ESC:  entry.cls = CLS_ESC;
      CH_FF:   entry.cls = CLS_FF;
      CH_BEL:  entry.cls = CLS_BELL;
      CH_LF:   entry.cls = CLS_LF;
      CH_FS:   entry.cls = CLS_FS;
      CH_GS:   entry.cls = CLS_GS;
      CH_RS:   entry.cls = CLS_RS;
      default: entry.cls = CLS_DATA;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/vtsd_fifo.sv
// Two-entry request queue between the front and back parts.
// Depends on vtsd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module vtsd_fifo import vtsd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  entry_t    wdata,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output entry_t    rdata
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vtsd_div.sv
// Serial remainder unit for tab stops: one quotient bit per cycle, restoring form.
// Depends on vtsd_pkg for the divisor width.
`timescale 1ns / 1ps
`default_nettype none
module vtsd_div import vtsd_pkg::*; #(
  parameter int DW = 13,
  parameter int VW = DVS_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [VW-1:0]      remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quotient;
  logic [VW:0]   trial;
  logic          take;

  assign trial = {remainder, quotient[DW-1]};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(DW);
      end else if (active) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (active) begin
      quotient  <= {quotient[DW-2:0], take};
      remainder <= take ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vtsd_back.sv
// Back part: parser state, cursor and pen, drawing command output register.
// Depends on vtsd_pkg (cell size functions) and vtsd_div (tab stop remainder).
`timescale 1ns / 1ps
`default_nettype none
module vtsd_back import vtsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic cfg_wr,
  input  wire logic q_valid,
  input  entry_t    q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      result
);

  localparam int CB = COORD_BITS;
  localparam int DW = (CB > 13) ? CB : 13;
  localparam int SW = DW + 2;
  localparam logic [CB-1:0] MASK = CB'((1 << CB) - 1);
  localparam logic signed [SW-1:0] FOUR = 4;
  localparam logic signed [SW-1:0] ONE  = 1;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic [CB-1:0]        m;
  } txt_t;

  bstate_t state, state_next;
  entry_t  cur;

  mode_t         mode;
  logic [9:0]    high_y, high_x;
  logic [4:0]    low_y, low_x, extra;
  logic [CB-1:0] cursor_x, cursor_y, margin;
  logic          point_plot, special_plot, pen_down, through;
  logic [2:0]    style;
  logic [1:0]    size;

  logic [7:0]       hd, vd;
  logic [1:0]       cache_size, need_size;
  logic             cache_valid, cache_hit, tab_mod;
  logic [DVS_W-1:0] mod_rem;
  logic             commit;

  logic             div_start, div_done;
  logic [DW-1:0]    div_dividend;
  logic [DVS_W-1:0] div_divisor, div_rem;

  logic signed [SW-1:0] w_s, h_s, hd_s, vd_s;

  // Results of the current byte, valid in BS_EXEC.
  mode_t         n_mode;
  logic [9:0]    n_high_y, n_high_x;
  logic [4:0]    n_low_y, n_low_x, n_extra;
  logic [CB-1:0] n_cx, n_cy, n_margin, n_px, n_py;
  logic          n_pp, n_sp, n_pen, n_through;
  logic [2:0]    n_style;
  logic [1:0]    n_size;
  cmd_t          n_cmd;
  logic [6:0]    n_glyph, n_inten;
  logic          n_defoc;

  vtsd_div #(.DW(DW), .VW(DVS_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  function automatic logic signed [SW-1:0] ext_c(input logic [CB-1:0] v);
    return $signed({{(SW-CB){1'b0}}, v});
  endfunction

  assign w_s  = $signed({{(SW-13){1'b0}}, cfg.width});
  assign h_s  = $signed({{(SW-13){1'b0}}, cfg.height});
  assign hd_s = $signed({{(SW-8){1'b0}}, hd});
  assign vd_s = $signed({{(SW-8){1'b0}}, vd});

  function automatic txt_t limit_text(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
                                      input logic [CB-1:0] m);
    txt_t r;
    r.x = x;
    r.y = y;
    r.m = m;
    if (r.x < 0) begin
      r.x = '0;
    end
    if (r.x > w_s - hd_s) begin
      r.x = ext_c(r.m);
      r.y = r.y - vd_s;
    end
    // Falling off the bottom flips between the left and right column halves.
    if (r.y < FOUR) begin
      r.y = h_s - vd_s;
      r.m = (r.m != '0) ? '0 : CB'(cfg.width >> 1);
      if (r.x < ext_c(r.m)) begin
        r.x = ext_c(r.m);
      end
    end
    if (r.y > h_s - vd_s) begin
      r.y = h_s - vd_s;
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] sat_step(input logic signed [SW-1:0] v,
                                                    input logic up, input logic down,
                                                    input logic [12:0] dim);
    logic [DW-1:0]        top;
    logic signed [SW-1:0] r;
    top = (dim == 13'd0) ? '0 : DW'(dim - 13'd1);
    if (top > DW'(MASK)) begin
      top = DW'(MASK);
    end
    r = v;
    if (up != down) begin
      r = up ? r + ONE : r - ONE;
      if (r < 0) begin
        r = '0;
      end
      if (r > $signed({2'b00, top})) begin
        r = $signed({2'b00, top});
      end
    end
    return r;
  endfunction

  function automatic logic [11:0] compose(input logic [9:0] hi, input logic [4:0] lo,
                                          input logic [1:0] fine);
    logic [9:0] s;
    s = hi + {5'b0, lo};
    return cfg.full_res ? {s, fine} : {2'b00, s};
  endfunction

  assign need_size    = (q_head.cls == CLS_FF) ? 2'd0 : size;
  assign cache_hit    = cache_valid && (cache_size == need_size);
  assign tab_mod      = (cur.cls == CLS_DATA) && (cur.ch == CH_HT) && !cfg.tab_single &&
                        (mode == MODE_ALPHA || mode == MODE_ESC) && (hd != 8'd0);
  assign commit       = (state == BS_EXEC) && (!out_valid || out_ready);
  assign div_dividend = DW'(cursor_x);
  assign div_divisor  = DVS_W'({hd, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (cache_hit) begin
            state_next = BS_PREP;
          end else begin
            state_next = BS_CELL;
          end
        end
      end
      BS_CELL: begin
        state_next = BS_PREP;
      end
      BS_PREP: begin
        if (tab_mod) begin
          div_start  = 1'b1;
          state_next = BS_MOD;
        end else begin
          state_next = BS_EXEC;
        end
      end
      BS_MOD: begin
        if (div_done) begin
          state_next = BS_EXEC;
        end
      end
      BS_EXEC: begin
        if (commit) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid <= 1'b0;
    end else if (cfg_wr) begin
      cache_valid <= 1'b0;
    end else if (state == BS_CELL) begin
      cache_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      if (!cache_hit) begin
        cache_size <= need_size;
      end
    end
    if (state == BS_CELL) begin
      hd <= cell_width(cfg.width, cache_size);
      vd <= cell_height(cfg.height, cache_size);
    end
    if (state == BS_MOD && div_done) begin
      mod_rem <= div_rem;
    end
  end

  always_comb begin
    mode_t                m;
    logic                 run;
    logic                 edit_bs, edit_ht, edit_vt;
    logic [1:0]           tag;
    logic [6:0]           ch;
    logic signed [SW-1:0] cx, cy, px, py;
    logic                 glyph_pos;
    txt_t                 t;
    logic [CB-1:0]        mg;

    ch        = cur.ch;
    tag       = ch[6:5];
    cx        = ext_c(cursor_x);
    cy        = ext_c(cursor_y);
    px        = '0;
    py        = '0;
    t         = '0;
    mg        = margin;
    glyph_pos = 1'b0;
    edit_bs   = 1'b0;
    edit_ht   = 1'b0;
    edit_vt   = 1'b0;
    run       = 1'b1;
    m         = mode;
    n_mode    = mode;
    n_high_y  = high_y;
    n_high_x  = high_x;
    n_low_y   = low_y;
    n_low_x   = low_x;
    n_extra   = extra;
    n_pp      = point_plot;
    n_sp      = special_plot;
    n_pen     = pen_down;
    n_through = through;
    n_style   = style;
    n_size    = size;
    n_cmd     = CMD_NONE;
    n_glyph   = '0;
    n_inten   = '0;
    n_defoc   = 1'b0;

    if (cur.cls == CLS_US || cur.cls == CLS_CR || cur.cls == CLS_ESC || cur.cls == CLS_FF) begin
      n_mode = (cur.cls == CLS_ESC) ? MODE_ESC : MODE_ALPHA;
      n_pp   = 1'b0;
      n_sp   = 1'b0;
      if (cur.cls == CLS_CR) begin
        cx = ext_c(margin);
      end
      if (cur.cls == CLS_FF) begin
        n_cmd  = CMD_CLEAR;
        n_size = 2'd0;
        mg     = '0;
        cx     = '0;
        cy     = h_s - vd_s;
      end
    end else if (cur.cls == CLS_BELL) begin
      n_cmd = CMD_BELL;
    end else if (cur.cls == CLS_LF) begin
      cy = cy - vd_s;
      if (!cfg.raw_nl) begin
        cx = ext_c(margin);
      end
      t  = limit_text(cx, cy, mg);
      cx = t.x;
      cy = t.y;
      mg = t.m;
    end else if (cur.cls == CLS_FS && mode != MODE_ESC) begin
      n_mode = PLOT_HY;
      n_pp   = 1'b1;
    end else if (cur.cls == CLS_GS) begin
      n_mode = MODE_HY;
      n_pp   = 1'b0;
    end else if (cur.cls == CLS_RS) begin
      n_pen  = 1'b1;
      n_mode = MODE_INCR;
    end else begin
      // Address bytes may skip ahead: the tag tells which byte really came.
      if (m >= MODE_HY && m <= PLOT_LX) begin
        if (tag == TAG_CTL) begin
          run = 1'b0;
        end else begin
          if (m == MODE_HY && tag != TAG_HIGH) m = MODE_LY;
          if (m == MODE_HX && tag == TAG_LOWY) begin
            m       = MODE_LY;
            n_extra = low_y;
          end
          if (m == MODE_LY && tag != TAG_LOWY) m = MODE_HX;
          if (m == MODE_HX && tag != TAG_HIGH) m = MODE_LX;
          if (m == PLOT_HY && tag != TAG_HIGH) m = PLOT_LY;
          if (m == PLOT_HX && tag == TAG_LOWY) begin
            m       = PLOT_LY;
            n_extra = low_y;
          end
          if (m == PLOT_LY && tag != TAG_LOWY) m = PLOT_HX;
          if (m == PLOT_HX && tag != TAG_HIGH) m = PLOT_LX;
          n_mode = m;
        end
      end
      if (run) begin
        unique case (m)
          MODE_HY: begin
            n_pp     = 1'b0;
            n_high_y = {ch[4:0], 5'b0};
            n_mode   = MODE_LY;
          end
          MODE_LY: begin
            n_low_y = ch[4:0];
            cy      = ext_c(CB'(compose(high_y, ch[4:0], n_extra[3:2])));
            n_mode  = MODE_HX;
          end
          MODE_HX: begin
            if (tag == TAG_HIGH) begin
              n_high_x = {ch[4:0], 5'b0};
            end
            n_mode = MODE_LX;
          end
          MODE_LX: begin
            n_low_x = ch[4:0];
            cx      = ext_c(CB'(compose(high_x, ch[4:0], n_extra[1:0])));
            n_cmd   = CMD_MOVE;
            n_mode  = PLOT_HY;
          end
          PLOT_HY: begin
            n_high_y = {ch[4:0], 5'b0};
            n_mode   = PLOT_LY;
          end
          PLOT_LY: begin
            n_low_y = ch[4:0];
            n_mode  = PLOT_HX;
          end
          PLOT_HX: begin
            n_high_x = {ch[4:0], 5'b0};
            n_mode   = PLOT_LX;
          end
          PLOT_LX: begin
            n_low_x = ch[4:0];
            cx      = ext_c(CB'(compose(high_x, ch[4:0], n_extra[1:0])));
            cy      = ext_c(CB'(compose(high_y, low_y, n_extra[3:2])));
            n_cmd   = point_plot ? CMD_POINT : CMD_VECTOR;
            n_mode  = special_plot ? MODE_SPECIAL : PLOT_HY;
          end
          MODE_ESC: begin
            if (ch == CH_NUL || ch == CH_ACK || ch == CH_SO || ch == CH_SI || ch == CH_LBRK) begin
              n_mode = MODE_ESC;
            end else if (ch == CH_BS) begin
              edit_bs = 1'b1;
              n_mode  = MODE_ALPHA;
            end else if (ch == CH_HT) begin
              edit_ht = 1'b1;
              n_mode  = MODE_ALPHA;
            end else if (ch == CH_VT) begin
              edit_vt = 1'b1;
              n_mode  = MODE_ALPHA;
            end else if (ch == CH_ETB) begin
              n_cmd  = CMD_DUMP;
              n_mode = MODE_ALPHA;
            end else if (ch == CH_FS) begin
              n_mode = MODE_SPECIAL;
              n_sp   = 1'b1;
            end else if (ch >= CH_EIGHT && ch <= CH_SEMI) begin
              n_size = ch[1:0];
              n_cmd  = CMD_SIZE;
              n_mode = MODE_ALPHA;
            end else if (ch >= CH_GRAVE && ch <= CH_LO_G) begin
              n_style   = (ch[2:0] <= 3'd4) ? ch[2:0] : 3'd0;
              n_through = 1'b0;
              n_cmd     = CMD_STYLE;
              n_mode    = MODE_ALPHA;
            end else if (ch >= CH_LO_H && ch <= CH_LO_O) begin
              n_mode = MODE_SKIP;
            end else if (ch >= CH_LO_P && ch <= CH_LO_W) begin
              n_style   = (ch[2:0] <= 3'd4) ? ch[2:0] : 3'd0;
              n_through = 1'b1;
              n_cmd     = CMD_STYLE;
              n_mode    = MODE_SKIP;
            end else begin
              n_mode = MODE_ALPHA;
            end
          end
          MODE_INCR: begin
            if (ch == CH_SPACE) begin
              n_pen = 1'b0;
            end else if (ch == CH_PEN) begin
              n_pen = 1'b1;
            end else if (ch[6:4] == 3'b100) begin
              cx    = sat_step(cx, ch[0], ch[1], cfg.width);
              cy    = sat_step(cy, ch[2], ch[3], cfg.height);
              n_cmd = pen_down ? CMD_POINT : CMD_MOVE;
            end
          end
          MODE_SPECIAL: begin
            if (ch >= CH_SPACE && ch < CH_SPACE + 7'(INTENSITY_ENTRIES)) begin
              n_defoc = (ch[6:5] == 2'd1);
              n_inten = INTENSITY_TAB[ch - CH_SPACE];
              n_cmd   = CMD_INTENSITY;
              n_mode  = PLOT_HY;
            end
          end
          MODE_SKIP: begin
            n_mode = MODE_SKIP;
          end
          MODE_ALPHA: begin
            if (ch == CH_BS) begin
              edit_bs = 1'b1;
            end else if (ch == CH_HT) begin
              edit_ht = 1'b1;
            end else if (ch == CH_VT) begin
              edit_vt = 1'b1;
            end else if (ch == CH_ETB) begin
              n_cmd = CMD_DUMP;
            end else if (ch >= CH_SPACE && ch < CH_DEL) begin
              t         = limit_text(cx, cy, mg);
              mg        = t.m;
              px        = t.x;
              py        = t.y;
              cx        = t.x + hd_s;
              cy        = t.y;
              glyph_pos = 1'b1;
              n_glyph   = ch;
              n_cmd     = CMD_CHAR;
            end
          end
          default: n_mode = MODE_ALPHA;
        endcase
      end
    end

    if (edit_bs || edit_ht || edit_vt) begin
      if (edit_bs) begin
        cx = cx - hd_s;
      end
      if (edit_vt) begin
        cy = cy + vd_s;
      end
      if (edit_ht) begin
        if (cfg.tab_single) begin
          cx = cx + hd_s;
        end else if (hd != 8'd0) begin
          cx = cx - $signed({{(SW-DVS_W){1'b0}}, mod_rem})
                  + $signed({{(SW-11){1'b0}}, hd, 3'b000});
        end
      end
      t  = limit_text(cx, cy, mg);
      cx = t.x;
      cy = t.y;
      mg = t.m;
    end

    n_cx     = CB'(cx);
    n_cy     = CB'(cy);
    n_margin = mg;
    n_px     = glyph_pos ? CB'(px) : n_cx;
    n_py     = glyph_pos ? CB'(py) : n_cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ALPHA;
      high_y       <= '0;
      low_y        <= '0;
      high_x       <= '0;
      low_x        <= '0;
      extra        <= '0;
      cursor_x     <= '0;
      cursor_y     <= CB'(RESET_CURSOR_Y);
      margin       <= '0;
      point_plot   <= 1'b0;
      special_plot <= 1'b0;
      pen_down     <= 1'b1;
      style        <= '0;
      through      <= 1'b0;
      size         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (commit) begin
        mode         <= n_mode;
        high_y       <= n_high_y;
        low_y        <= n_low_y;
        high_x       <= n_high_x;
        low_x        <= n_low_x;
        extra        <= n_extra;
        cursor_x     <= n_cx;
        cursor_y     <= n_cy;
        margin       <= n_margin;
        point_plot   <= n_pp;
        special_plot <= n_sp;
        pen_down     <= n_pen;
        style        <= n_style;
        through      <= n_through;
        size         <= n_size;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.command        <= n_cmd;
      result.from_x         <= 12'(cursor_x);
      result.from_y         <= 12'(cursor_y);
      result.to_x           <= 12'(n_px);
      result.to_y           <= 12'(n_py);
      result.glyph_code     <= n_glyph;
      result.glyph_size     <= n_size;
      result.line_style     <= n_style;
      result.write_through  <= n_through;
      result.beam_intensity <= n_inten;
      result.defocused      <= n_defoc;
      result.alpha_mode     <= (n_mode == MODE_ALPHA);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vector_terminal_stream_decoder_unit.sv
// Top level of the vector terminal stream decoder: configuration registers,
// front classifier, request queue and back part. Depends on vtsd_pkg and all vtsd_* modules.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------
//   rx      | rx_valid / rx_ready   | rx_byte
//   out     | out_valid / out_ready | command, from/to x/y, glyph, style, intensity
//   cfg     | cfg_write_en          | cfg_index, cfg_data
//
// When the character cell size is cached, a byte passes from acceptance to its command
// through dispatch, preparation and execution in the back part; execution waits while
// the output stalls, and the back part takes no new byte before the last one is done.
// After a configuration write or a size change, an extra cell state loads the cell width
// and height from reciprocal multiplications.
// A tab to the next eight-cell stop adds a wait on the serial remainder unit.
// Reset is synchronous; a two-entry queue lets input accept while the output stalls.
`timescale 1ns / 1ps
`default_nettype none
module vector_terminal_stream_decoder_unit import vtsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             rx_valid,
  output logic                  rx_ready,
  input  wire logic [7:0]       rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            command,
  output logic [11:0]           from_x,
  output logic [11:0]           from_y,
  output logic [11:0]           to_x,
  output logic [11:0]           to_y,
  output logic [6:0]            glyph_code,
  output logic [1:0]            glyph_size,
  output logic [2:0]            line_style,
  output logic                  write_through,
  output logic [6:0]            beam_intensity,
  output logic                  defocused,
  output logic                  alpha_mode
);

  cfg_t   cfg;
  entry_t front_entry, head;
  logic   push, q_full, q_valid, q_pop;
  res_t   result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width      <= RESET_WIDTH;
      cfg.height     <= RESET_HEIGHT;
      cfg.tab_single <= 1'b0;
      cfg.full_res   <= 1'b0;
      cfg.raw_nl     <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.width      <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.height     <= cfg_data;
        REG_TAB_SINGLE:    cfg.tab_single <= cfg_data[0];
        REG_FULL_RES:      cfg.full_res   <= cfg_data[0];
        REG_RAW_NEWLINE:   cfg.raw_nl     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vtsd_front u_front (
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_ready (rx_ready),
    .q_full   (q_full),
    .push     (push),
    .entry    (front_entry)
  );

  vtsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (head)
  );

  vtsd_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_wr    (cfg_write_en),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign command        = result.command;
  assign from_x         = result.from_x;
  assign from_y         = result.from_y;
  assign to_x           = result.to_x;
  assign to_y           = result.to_y;
  assign glyph_code     = result.glyph_code;
  assign glyph_size     = result.glyph_size;
  assign line_style     = result.line_style;
  assign write_through  = result.write_through;
  assign beam_intensity = result.beam_intensity;
  assign defocused      = result.defocused;
  assign alpha_mode     = result.alpha_mode;

endmodule
`default_nettype wire
